@@ src/dsf_pkg.sv @@
// Shared types, constants and codes for the directional stripe filter.
package dsf_pkg;

    // Default sizing
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_MAX_REACH   = 31;
    localparam int DEF_FRAC_BITS   = 14;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 21;
    localparam int CRD_W      = 9;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEEP_MODE  = 4'd0,
        CFG_SLOPE       = 4'd1,
        CFG_REACH_X     = 4'd2,
        CFG_REACH_Y     = 4'd3,
        CFG_TOL_NARROW  = 4'd4,
        CFG_TOL_WIDE    = 4'd5,
        CFG_GRID_WIDTH  = 4'd6,
        CFG_GRID_HEIGHT = 4'd7
    } cfg_idx_t;

    // Input kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTRE_RD,
        ST_CENTRE_CHK,
        ST_WALK,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_DIV_CHK,
        ST_DIV_N,
        ST_DIV_W,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic in_take;
        logic centre_rd;
        logic walk_init;
        logic walk_rd;
        logic div_go_n;
        logic div_go_w;
        logic mean_n_cap;
        logic mean_w_cap;
        logic res_nodata;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic in_valid;
        logic in_kind;
        logic centre_ok;
        logic walk_last;
        logic bands_ok;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

@@ src/dsf_if.sv @@
// Valid/ready channel interfaces for input items and results.
interface dsf_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [31:0] value;
    logic               present;

    modport source (output valid, kind, col, row, value, present, input ready);
    modport sink (input valid, kind, col, row, value, present, output ready);
endinterface

interface dsf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mean_narrow;
    logic signed [31:0] mean_wide;
    logic signed [32:0] stripe_error;
    logic signed [33:0] destriped;
    logic               has_data;

    modport source (output valid, mean_narrow, mean_wide, stripe_error, destriped,
                    has_data, input ready);
    modport sink (input valid, mean_narrow, mean_wide, stripe_error, destriped,
                  has_data, output ready);
endinterface

@@ src/dsf_ram.sv @@
// Generic single write port RAM with registered read.
module dsf_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/dsf_div.sv @@
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module dsf_div #(
    parameter int SUM_W   = 44,
    parameter int CNT_W   = 12,
    parameter int VALUE_W = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic signed [SUM_W-1:0]   dividend,
    input  logic [CNT_W-1:0]          divisor,
    output logic                      done,
    output logic signed [VALUE_W-1:0] quotient
);
    localparam int IT_W = $clog2(SUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [IT_W-1:0]  it_reg, it_next;
    logic [SUM_W-1:0] q_reg, q_next;
    logic [CNT_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic [CNT_W:0]   rem_sh;
    logic [SUM_W-1:0] q_signed;

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // One shift-subtract step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[CNT_W-1:0], q_reg[SUM_W-1]};
        if (go)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            neg_next  = dividend[SUM_W-1];
            q_next    = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                q_next   = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[SUM_W-2:0], 1'b0};
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[VALUE_W-1:0];
    assign done     = done_reg;
endmodule

@@ src/dsf_ctrl.sv @@
// Controller state machine sequencing clear, load, window walk and division.
module dsf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  dsf_pkg::status_t sts,
    output dsf_pkg::cmd_t    cmd,
    output logic             in_ready
);
    import dsf_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.in_take = 1'b1;
                    if (sts.in_kind == KIND_COMPUTE)
                    begin
                        state_next = ST_CENTRE_RD;
                    end
                end
            end
            ST_CENTRE_RD:
            begin
                cmd.centre_rd = 1'b1;
                state_next    = ST_CENTRE_CHK;
            end
            ST_CENTRE_CHK:
            begin
                if (sts.centre_ok)
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_WALK;
                end
                else
                begin
                    cmd.res_nodata = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_DIV_CHK;
            ST_DIV_CHK:
            begin
                if (sts.bands_ok)
                begin
                    cmd.div_go_n = 1'b1;
                    state_next   = ST_DIV_N;
                end
                else
                begin
                    cmd.res_nodata = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_DIV_N:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_n_cap = 1'b1;
                    cmd.div_go_w   = 1'b1;
                    state_next     = ST_DIV_W;
                end
            end
            ST_DIV_W:
            begin
                if (sts.div_done)
                begin
                    cmd.mean_w_cap = 1'b1;
                    state_next     = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

@@ src/dsf_datapath.sv @@
// Datapath: configuration, frame memory, window walk, band sums and results.
module dsf_datapath #(
    parameter int MAX_WIDTH   = dsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = dsf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_REACH   = dsf_pkg::DEF_MAX_REACH,
    parameter int FRAC_BITS   = dsf_pkg::DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = dsf_pkg::DEF_VALUE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dsf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  dsf_pkg::cmd_t                   cmd,
    output dsf_pkg::status_t                sts,
    dsf_in_if.sink                          in_ch,
    dsf_out_if.source                       out_ch
);
    import dsf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_REACH + 1) + 1;
    localparam int CNT_W = $clog2((2 * MAX_REACH + 1) * (2 * MAX_REACH + 1) + 1);
    localparam int SUM_W = VALUE_WIDTH + CNT_W;
    localparam int RW    = DW + 16;
    localparam int CW    = DW + FRAC_BITS + 24;

    // Configuration registers
    logic               steep_reg;
    logic signed [15:0] slope_reg;
    logic [4:0]         reach_x_reg, reach_y_reg;
    logic [20:0]        tol_n_reg, tol_w_reg;
    logic [8:0]         gw_cfg_reg, gh_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steep_reg   <= 1'b1;
            slope_reg   <= '0;
            reach_x_reg <= 5'd20;
            reach_y_reg <= 5'd1;
            tol_n_reg   <= 21'd8192;
            tol_w_reg   <= 21'd16384;
            gw_cfg_reg  <= 9'd256;
            gh_cfg_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STEEP_MODE:  steep_reg   <= cfg_data[0];
                CFG_SLOPE:       slope_reg   <= cfg_data[15:0];
                CFG_REACH_X:     reach_x_reg <= cfg_data[4:0];
                CFG_REACH_Y:     reach_y_reg <= cfg_data[4:0];
                CFG_TOL_NARROW:  tol_n_reg   <= cfg_data;
                CFG_TOL_WIDE:    tol_w_reg   <= cfg_data;
                CFG_GRID_WIDTH:  gw_cfg_reg  <= cfg_data[8:0];
                CFG_GRID_HEIGHT: gh_cfg_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective grid size and reach
    logic [CRD_W-1:0] gw, gh;
    logic [4:0]       rx, ry;

    always_comb
    begin
        if (gw_cfg_reg == '0)
            gw = CRD_W'(1);
        else if (32'(gw_cfg_reg) > 32'(MAX_WIDTH))
            gw = CRD_W'(MAX_WIDTH);
        else
            gw = gw_cfg_reg;
        if (gh_cfg_reg == '0)
            gh = CRD_W'(1);
        else if (32'(gh_cfg_reg) > 32'(MAX_HEIGHT))
            gh = CRD_W'(MAX_HEIGHT);
        else
            gh = gh_cfg_reg;
        rx = (32'(reach_x_reg) > 32'(MAX_REACH)) ? 5'(MAX_REACH) : reach_x_reg;
        ry = (32'(reach_y_reg) > 32'(MAX_REACH)) ? 5'(MAX_REACH) : reach_y_reg;
    end

    // Clearing pass counter
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_wr)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end

    // Item latch
    logic [CRD_W-1:0] col_reg, row_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            col_reg <= CRD_W'(in_ch.col);
            row_reg <= CRD_W'(in_ch.row);
        end
    end

    // Window walk
    logic [CRD_W-1:0] ix_reg, iy_reg, x0_reg, x1_reg, y1_reg;
    logic [CRD_W-1:0] x0, x1, y0, y1;
    logic [CRD_W:0]   xe, ye;

    always_comb
    begin
        x0 = (col_reg >= CRD_W'(rx)) ? col_reg - CRD_W'(rx) : '0;
        y0 = (row_reg >= CRD_W'(ry)) ? row_reg - CRD_W'(ry) : '0;
        xe = {1'b0, col_reg} + (CRD_W + 1)'(rx);
        ye = {1'b0, row_reg} + (CRD_W + 1)'(ry);
        x1 = (xe > {1'b0, gw - 1'b1}) ? gw - 1'b1 : xe[CRD_W-1:0];
        y1 = (ye > {1'b0, gh - 1'b1}) ? gh - 1'b1 : ye[CRD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            ix_reg <= x0;
            iy_reg <= y0;
            x0_reg <= x0;
            x1_reg <= x1;
            y1_reg <= y1;
        end
        else if (cmd.walk_rd)
        begin
            if (ix_reg == x1_reg)
            begin
                ix_reg <= x0_reg;
                iy_reg <= iy_reg + 1'b1;
            end
            else
            begin
                ix_reg <= ix_reg + 1'b1;
            end
        end
    end

    // Frame memory: value and presence bit per entry
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [VALUE_WIDTH:0] ram_wdata, ram_rdata;
    logic [31:0]          load_lin, centre_lin, walk_lin;
    logic                 load_ok;

    always_comb
    begin
        load_lin   = 32'(in_ch.row) * 32'(MAX_WIDTH) + 32'(in_ch.col);
        centre_lin = 32'(row_reg) * 32'(MAX_WIDTH) + 32'(col_reg);
        walk_lin   = 32'(iy_reg) * 32'(MAX_WIDTH) + 32'(ix_reg);
        load_ok    = (32'(in_ch.col) < 32'(MAX_WIDTH)) && (32'(in_ch.row) < 32'(MAX_HEIGHT));
        ram_we     = 1'b0;
        ram_waddr  = load_lin[AW-1:0];
        ram_wdata  = {in_ch.present, in_ch.value[VALUE_WIDTH-1:0]};
        if (cmd.clr_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.in_take && in_ch.kind == KIND_LOAD && load_ok)
        begin
            ram_we = 1'b1;
        end
        ram_raddr = cmd.centre_rd ? centre_lin[AW-1:0] : walk_lin[AW-1:0];
    end

    dsf_ram #(
        .WIDTH (VALUE_WIDTH + 1),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic                          rd_present;
    logic signed [VALUE_WIDTH-1:0] rd_value;
    assign rd_present = ram_rdata[VALUE_WIDTH];
    assign rd_value   = ram_rdata[VALUE_WIDTH-1:0];

    // Offsets of the read in flight
    logic signed [CRD_W+1:0] dx_full, dy_full;
    logic signed [DW-1:0]    p1_dm_reg, p1_ds_reg;
    logic                    p1_vld_reg;

    assign dx_full = $signed({2'b00, col_reg}) - $signed({2'b00, ix_reg});
    assign dy_full = $signed({2'b00, row_reg}) - $signed({2'b00, iy_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else
            p1_vld_reg <= cmd.walk_rd;
    end

    always_ff @(posedge clk)
    begin
        p1_dm_reg <= steep_reg ? dy_full[DW-1:0] : dx_full[DW-1:0];
        p1_ds_reg <= steep_reg ? dx_full[DW-1:0] : dy_full[DW-1:0];
    end

    // Product stage
    logic                          p2_vld_reg;
    logic signed [RW-1:0]          p2_ref_reg;
    logic signed [DW-1:0]          p2_ds_reg;
    logic signed [VALUE_WIDTH-1:0] p2_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_vld_reg <= 1'b0;
        else
            p2_vld_reg <= p1_vld_reg && rd_present;
    end

    always_ff @(posedge clk)
    begin
        p2_ref_reg <= RW'(p1_dm_reg) * RW'(slope_reg);
        p2_ds_reg  <= p1_ds_reg;
        p2_val_reg <= rd_value;
    end

    // Band test and accumulation
    logic signed [CW-1:0]    ref_x, d_x, tn_x, tw_x;
    logic                    in_n, in_w;
    logic signed [SUM_W-1:0] sum_n_reg, sum_w_reg;
    logic [CNT_W-1:0]        cnt_n_reg, cnt_w_reg;

    always_comb
    begin
        ref_x = CW'(p2_ref_reg);
        d_x   = CW'(p2_ds_reg) <<< FRAC_BITS;
        tn_x  = CW'(tol_n_reg);
        tw_x  = CW'(tol_w_reg);
        in_n  = (d_x >= ref_x - tn_x) && (d_x <= ref_x + tn_x);
        in_w  = (d_x >= ref_x - tw_x) && (d_x <= ref_x + tw_x);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            sum_n_reg <= '0;
            sum_w_reg <= '0;
            cnt_n_reg <= '0;
            cnt_w_reg <= '0;
        end
        else if (p2_vld_reg)
        begin
            if (in_n)
            begin
                sum_n_reg <= sum_n_reg + SUM_W'(p2_val_reg);
                cnt_n_reg <= cnt_n_reg + 1'b1;
            end
            if (in_w)
            begin
                sum_w_reg <= sum_w_reg + SUM_W'(p2_val_reg);
                cnt_w_reg <= cnt_w_reg + 1'b1;
            end
        end
    end

    // Shared divider
    logic                          div_go, div_done;
    logic signed [SUM_W-1:0]       div_num;
    logic [CNT_W-1:0]              div_den;
    logic signed [VALUE_WIDTH-1:0] div_q;

    assign div_go  = cmd.div_go_n || cmd.div_go_w;
    assign div_num = cmd.div_go_w ? sum_w_reg : sum_n_reg;
    assign div_den = cmd.div_go_w ? cnt_w_reg : cnt_n_reg;

    dsf_div #(
        .SUM_W   (SUM_W),
        .CNT_W   (CNT_W),
        .VALUE_W (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // Result staging
    logic signed [VALUE_WIDTH-1:0] centre_reg, mn_reg, mw_reg;
    logic                          res_hd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
            centre_reg <= rd_value;
        if (cmd.mean_n_cap)
            mn_reg <= div_q;
        if (cmd.mean_w_cap)
        begin
            mw_reg     <= div_q;
            res_hd_reg <= 1'b1;
        end
        else if (cmd.res_nodata)
        begin
            res_hd_reg <= 1'b0;
        end
    end

    // Output register
    logic               out_vld_reg;
    logic signed [31:0] o_mn_reg, o_mw_reg;
    logic signed [32:0] o_err_reg;
    logic signed [33:0] o_des_reg;
    logic               o_hd_reg;
    logic signed [32:0] err;

    assign err = 33'(mw_reg) - 33'(mn_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cmd.out_load)
            out_vld_reg <= 1'b1;
        else if (out_ch.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_hd_reg <= res_hd_reg;
            if (res_hd_reg)
            begin
                o_mn_reg  <= 32'(mn_reg);
                o_mw_reg  <= 32'(mw_reg);
                o_err_reg <= err;
                o_des_reg <= 34'(err) + 34'(centre_reg);
            end
            else
            begin
                o_mn_reg  <= '0;
                o_mw_reg  <= '0;
                o_err_reg <= '0;
                o_des_reg <= '0;
            end
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.mean_narrow  = o_mn_reg;
    assign out_ch.mean_wide    = o_mw_reg;
    assign out_ch.stripe_error = o_err_reg;
    assign out_ch.destriped    = o_des_reg;
    assign out_ch.has_data     = o_hd_reg;

    // Status to controller
    always_comb
    begin
        sts.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
        sts.in_valid  = in_ch.valid;
        sts.in_kind   = in_ch.kind;
        sts.centre_ok = (col_reg < gw) && (row_reg < gh) && rd_present;
        sts.walk_last = (ix_reg == x1_reg) && (iy_reg == y1_reg);
        sts.bands_ok  = (cnt_n_reg != '0) && (cnt_w_reg != '0);
        sts.div_done  = div_done;
        sts.out_free  = !out_vld_reg || out_ch.ready;
    end
endmodule

@@ src/directional_stripe_filter_unit.sv @@
// Top level of the directional stripe filter: controller plus datapath.
//
//  channel  | direction | handshake    | content
//  in_ch    | in        | valid/ready  | kind, col, row, value, present
//  out_ch   | out       | valid/ready  | means, stripe_error, destriped, has_data
//  cfg      | in        | cfg_we only  | cfg_index, cfg_data
//
// A load is taken in ST_IDLE. A compute walks the clipped window, of area W
// (up to 63*63), one frame memory read a cycle,
// then two divisions at one bit a cycle in the shared divider.
// After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries clears the
// presence bits; no transaction is accepted until it ends.
// A finished result waits in the output register while loads go on.
module directional_stripe_filter_unit #(
    parameter int MAX_WIDTH   = dsf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = dsf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_REACH   = dsf_pkg::DEF_MAX_REACH,
    parameter int FRAC_BITS   = dsf_pkg::DEF_FRAC_BITS,
    parameter int VALUE_WIDTH = dsf_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dsf_pkg::CFG_DATA_W-1:0] cfg_data,
    dsf_in_if.sink                         in_ch,
    dsf_out_if.source                      out_ch
);
    import dsf_pkg::*;

    cmd_t    cmd;
    status_t sts;

    dsf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ch.ready)
    );

    dsf_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .MAX_REACH   (MAX_REACH),
        .FRAC_BITS   (FRAC_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );
endmodule

@@ test/tb_directional_stripe_filter_unit.sv @@
// Self-checking testbench for the directional stripe filter: frame and band-mean predictor.
module tb_directional_stripe_filter_unit;
    import dsf_pkg::*;

    localparam int      FRAME_W     = 256;
    localparam int      FRAME_CELLS = 65536;
    localparam int      REACH_CAP   = 31;
    localparam int      FRAC        = 14;
    localparam longint  CYCLE_LIMIT = 4000000;
    localparam int      SETTLE_CYC  = 40;
    // index past the last register, must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd13;

    typedef struct {
        logic signed [31:0] mean_narrow;
        logic signed [31:0] mean_wide;
        logic signed [32:0] stripe_error;
        logic signed [33:0] destriped;
        logic               has_data;
    } filt_res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dsf_in_if  in_ch ();
    dsf_out_if out_ch ();

    directional_stripe_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Predictor state: frame mirror and register copies
    logic signed [31:0] pix_val [FRAME_CELLS];
    bit                 pix_on  [FRAME_CELLS];
    bit     m_steep;
    longint m_slope;
    int     m_reach_x;
    int     m_reach_y;
    longint m_tol_n;
    longint m_tol_w;
    int     m_grid_w;
    int     m_grid_h;

    filt_res_t pending_means[$];
    int        fail_count;
    bit        quiet;
    longint    cycles = 0;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("directional_stripe_filter_unit regression: fail");
            $finish;
        end
    end

    // Band means for a centre pixel, from the mirrored frame
    function automatic filt_res_t filter_pixel(int c, int r);
        filt_res_t res;
        int     gw;
        int     gh;
        int     rx;
        int     ry;
        int     x0;
        int     x1;
        int     y0;
        int     y1;
        longint sum_n;
        longint sum_w;
        longint cnt_n;
        longint cnt_w;
        longint d;
        longint rf;
        longint v;
        longint mn;
        longint mw;
        longint err;
        res = '{default: 0};
        sum_n = 0;
        sum_w = 0;
        cnt_n = 0;
        cnt_w = 0;
        gw = (m_grid_w < 1) ? 1 : ((m_grid_w > FRAME_W) ? FRAME_W : m_grid_w);
        gh = (m_grid_h < 1) ? 1 : ((m_grid_h > FRAME_W) ? FRAME_W : m_grid_h);
        if (c >= gw || r >= gh)
            return res;
        if (!pix_on[r * FRAME_W + c])
            return res;
        rx = (m_reach_x > REACH_CAP) ? REACH_CAP : m_reach_x;
        ry = (m_reach_y > REACH_CAP) ? REACH_CAP : m_reach_y;
        x0 = (c - rx < 0) ? 0 : c - rx;
        x1 = (c + rx > gw - 1) ? gw - 1 : c + rx;
        y0 = (r - ry < 0) ? 0 : r - ry;
        y1 = (r + ry > gh - 1) ? gh - 1 : r + ry;
        for (int iy = y0; iy <= y1; iy++)
            for (int ix = x0; ix <= x1; ix++)
            begin
                if (!pix_on[iy * FRAME_W + ix])
                    continue;
                if (m_steep)
                begin
                    rf = longint'(r - iy) * m_slope;
                    d  = longint'(c - ix) <<< FRAC;
                end
                else
                begin
                    rf = longint'(c - ix) * m_slope;
                    d  = longint'(r - iy) <<< FRAC;
                end
                v = longint'(pix_val[iy * FRAME_W + ix]);
                if (d >= rf - m_tol_n && d <= rf + m_tol_n)
                begin
                    sum_n += v;
                    cnt_n++;
                end
                if (d >= rf - m_tol_w && d <= rf + m_tol_w)
                begin
                    sum_w += v;
                    cnt_w++;
                end
            end
        if (cnt_n == 0 || cnt_w == 0)
            return res;
        mn  = sum_n / cnt_n;
        mw  = sum_w / cnt_w;
        err = mw - mn;
        res.mean_narrow  = mn[31:0];
        res.mean_wide    = mw[31:0];
        res.stripe_error = err[32:0];
        res.destriped    = 34'(err + longint'(pix_val[r * FRAME_W + c]));
        res.has_data     = 1'b1;
        return res;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        filt_res_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_means.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_count++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (out_ch.mean_narrow !== want.mean_narrow)
                begin
                    $error("mean_narrow: expected %0d, got %0d", want.mean_narrow,
                           out_ch.mean_narrow);
                    fail_count++;
                end
                if (out_ch.mean_wide !== want.mean_wide)
                begin
                    $error("mean_wide: expected %0d, got %0d", want.mean_wide,
                           out_ch.mean_wide);
                    fail_count++;
                end
                if (out_ch.stripe_error !== want.stripe_error)
                begin
                    $error("stripe_error: expected %0d, got %0d", want.stripe_error,
                           out_ch.stripe_error);
                    fail_count++;
                end
                if (out_ch.destriped !== want.destriped)
                begin
                    $error("destriped: expected %0d, got %0d", want.destriped,
                           out_ch.destriped);
                    fail_count++;
                end
                if (out_ch.has_data !== want.has_data)
                begin
                    $error("has_data: expected %0d, got %0d", want.has_data,
                           out_ch.has_data);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure in random bursts
    int stall_left;
    always @(posedge clk)
    begin
        if (quiet)
            out_ch.ready <= 1'b1;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_ch.ready <= ($urandom_range(0, 2) != 0);
            stall_left   <= $urandom_range(1, 9) - 1;
        end
    end

    // Register write, mirrored into the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STEEP_MODE:  m_steep   = data[0];
            CFG_SLOPE:       m_slope   = longint'($signed(data[15:0]));
            CFG_REACH_X:     m_reach_x = data[4:0];
            CFG_REACH_Y:     m_reach_y = data[4:0];
            CFG_TOL_NARROW:  m_tol_n   = data[20:0];
            CFG_TOL_WIDE:    m_tol_w   = data[20:0];
            CFG_GRID_WIDTH:  m_grid_w  = data[8:0];
            CFG_GRID_HEIGHT: m_grid_h  = data[8:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_all(bit st, int sl, int rx, int ry, int tn, int tw, int gw, int gh);
        write_reg(CFG_STEEP_MODE, st);
        write_reg(CFG_SLOPE, sl);
        write_reg(CFG_REACH_X, rx);
        write_reg(CFG_REACH_Y, ry);
        write_reg(CFG_TOL_NARROW, tn);
        write_reg(CFG_TOL_WIDE, tw);
        write_reg(CFG_GRID_WIDTH, gw);
        write_reg(CFG_GRID_HEIGHT, gh);
    endtask

    // One input transaction; valid stays high for a following item unless a random gap follows
    task automatic send_item(logic knd, int c, int r, logic signed [31:0] v, logic p);
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= knd;
        in_ch.col     <= c[7:0];
        in_ch.row     <= r[7:0];
        in_ch.value   <= v;
        in_ch.present <= p;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (knd == KIND_LOAD)
        begin
            pix_val[c * 0 + r * FRAME_W + c] = v;
            pix_on[r * FRAME_W + c]          = p;
        end
        else
            pending_means.push_back(filter_pixel(c, r));
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic load_px(int c, int r, logic signed [31:0] v, logic p);
        send_item(KIND_LOAD, c, r, v, p);
    endtask

    task automatic compute_px(int c, int r);
        send_item(KIND_COMPUTE, c, r, $urandom(), $urandom_range(0, 1));
    endtask

    // Drain all results, then let the block go idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 200)) - 100;
            default: return $urandom();
        endcase
    endfunction

    // Grid corners, value extremes, clipping and no-data cases
    task automatic test_directed();
        set_all(1'b1, 0, 2, 1, 8192, 16384, 16, 16);
        load_px(0, 0, 32'sh7fffffff, 1'b1);
        load_px(1, 0, 32'sh80000000, 1'b1);
        load_px(2, 0, 32'sh7fffffff, 1'b1);
        load_px(0, 1, -32'sd5, 1'b1);
        load_px(1, 1, 32'sd7, 1'b0);
        load_px(255, 255, -32'sd1, 1'b1);
        load_px(254, 255, 32'sd3, 1'b1);
        compute_px(0, 0);
        compute_px(1, 0);
        compute_px(1, 1);
        compute_px(5, 5);
        compute_px(255, 255);
        settle();
        // zero grid size clamps to one pixel
        write_reg(CFG_GRID_WIDTH, 0);
        write_reg(CFG_GRID_HEIGHT, 0);
        write_reg(CFG_UNUSED, 21'h1fffff);
        compute_px(0, 0);
        compute_px(1, 0);
        settle();
        // oversize grid clamps to the full frame
        set_all(1'b0, -16384, 31, 31, 0, 1048576, 511, 511);
        compute_px(255, 255);
        settle();
        set_all(1'b1, 16384, 3, 3, 1048576, 0, 256, 256);
        compute_px(255, 255);
        compute_px(1, 0);
        settle();
    endtask

    task automatic random_config();
        int rx;
        int ry;
        rx = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 4);
        ry = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 31) : $urandom_range(0, 4);
        if (rx > 10 && ry > 10)
            ry = $urandom_range(0, 3);
        set_all($urandom_range(0, 1), int'($urandom_range(0, 32768)) - 16384, rx, ry,
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1048576)
                                            : $urandom_range(0, 40000),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1048576)
                                            : $urandom_range(0, 60000),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 48),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 48));
    endtask

    // Clustered loads and computes under random settings
    task automatic test_random(int phases, int per_phase);
        int bc;
        int br;
        for (int ph = 0; ph < phases; ph++)
        begin
            random_config();
            bc = $urandom_range(0, 40);
            br = $urandom_range(0, 40);
            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(0, 9) < 6)
                    load_px(($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                         : bc + $urandom_range(0, 8),
                            br + $urandom_range(0, 8), rand_value(),
                            $urandom_range(0, 4) != 0);
                else if ($urandom_range(0, 9) == 0)
                    compute_px($urandom_range(0, 255), $urandom_range(0, 255));
                else
                    compute_px(bc + $urandom_range(0, 8), br + $urandom_range(0, 8));
            end
            settle();
        end
    endtask

    // Sender holds off until every result is back, then resumes
    task automatic test_drain_pause();
        load_px(10, 10, 32'sd100, 1'b1);
        compute_px(10, 10);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_means.size() != 0)
            @(posedge clk);
        load_px(11, 10, 32'sd50, 1'b1);
        compute_px(10, 10);
        settle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_STEEP_MODE;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_LOAD;
        in_ch.col     = '0;
        in_ch.row     = '0;
        in_ch.value   = '0;
        in_ch.present = 1'b0;
        out_ch.ready  = 1'b0;
        fail_count    = 0;
        quiet         = 1'b0;
        stall_left    = 0;
        m_steep   = 1'b1;
        m_slope   = 0;
        m_reach_x = 20;
        m_reach_y = 1;
        m_tol_n   = 8192;
        m_tol_w   = 16384;
        m_grid_w  = 256;
        m_grid_h  = 256;
        for (int i = 0; i < FRAME_CELLS; i++)
        begin
            pix_on[i]  = 1'b0;
            pix_val[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset-value settings first
        load_px(20, 1, 32'sd9, 1'b1);
        compute_px(20, 1);
        settle();
        test_directed();
        test_random(4, 24);
        test_drain_pause();
        quiet = 1'b1;
        test_random(1, 20);

        settle();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("directional_stripe_filter_unit regression: pass");
        else
            $display("directional_stripe_filter_unit regression: fail");
        $finish;
    end

endmodule
